[hw/rtl/lpd_pkg.sv]
// lpd_pkg: shared types, constants and the nibble line code for the led pixel encoder
// no dependencies
package lpd_pkg;

  localparam int unsigned ResetCountDef  = 2;
  localparam int unsigned MaxResults     = 8;
  localparam int unsigned WordsPerPixel  = 6;
  localparam int unsigned QueueDepth     = 2;
  localparam logic [7:0]  DimReset       = 8'd4;
  localparam logic [7:0]  ByteMax        = 8'hFF;
  localparam logic [3:0]  LineOne        = 4'hE;
  localparam logic [3:0]  LineZero       = 4'h8;
  localparam logic        RegGlobalDim   = 1'b0;

  typedef struct packed {
    logic       start;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [15:0] nibble_code(input logic [3:0] nib);
    logic [15:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      w[i*4 +: 4] = nib[i] ? LineOne : LineZero;
    end
    return w;
  endfunction

endpackage

[hw/rtl/lpd_front.sv]
// lpd_front: accepts pixels and applies pixel scale and global dim in two stages
// depends on lpd_pkg
module lpd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            dim_level_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  start_frame_i,
  input  logic [7:0]            pixel_scale_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  lpd_pkg::q_stat_t      q_stat_i,
  output logic                  push_o,
  output lpd_pkg::pixel_t       push_data_o
);
  import lpd_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic       s1_start_q;
  logic [7:0] s1_scale_q;
  logic [8:0] s1_green_q, s1_red_q, s1_blue_q;

  logic [15:0] g_prod1, r_prod1, b_prod1;
  logic [16:0] g_prod2, r_prod2, b_prod2;
  logic [9:0]  g_sh, r_sh, b_sh;

  assign in_stall_o = s1_valid_q && q_stat_i.full;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  // first multiply: green by pixel scale, red and blue by global dim
  assign g_prod1 = 16'(green_i) * 16'(pixel_scale_i);
  assign r_prod1 = 16'(red_i) * 16'(dim_level_i);
  assign b_prod1 = 16'(blue_i) * 16'(dim_level_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      s1_start_q <= start_frame_i;
      s1_scale_q <= pixel_scale_i;
      s1_green_q <= g_prod1[15:7];
      s1_red_q   <= r_prod1[15:7];
      s1_blue_q  <= b_prod1[15:7];
    end
  end

  // second multiply and clip
  assign g_prod2 = 17'(s1_green_q) * 17'(dim_level_i);
  assign r_prod2 = 17'(s1_red_q) * 17'(s1_scale_q);
  assign b_prod2 = 17'(s1_blue_q) * 17'(s1_scale_q);
  assign g_sh    = g_prod2[16:7];
  assign r_sh    = r_prod2[16:7];
  assign b_sh    = b_prod2[16:7];

  always_comb begin
    push_data_o.start = s1_start_q;
    push_data_o.green = (g_sh > 10'(ByteMax)) ? ByteMax : g_sh[7:0];
    push_data_o.red   = (r_sh > 10'(ByteMax)) ? ByteMax : r_sh[7:0];
    push_data_o.blue  = (b_sh > 10'(ByteMax)) ? ByteMax : b_sh[7:0];
  end

  assign push_o = s1_valid_q && !q_stat_i.full;

endmodule

[hw/rtl/lpd_fifo.sv]
// lpd_fifo: short queue of scaled pixels between front and back
// depends on lpd_pkg
module lpd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::pixel_t  push_data_i,
  input  logic             pop_i,
  output lpd_pkg::pixel_t  head_o,
  output lpd_pkg::q_stat_t stat_o
);
  import lpd_pkg::*;

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(QueueDepth - 1);

  pixel_t        mem_q [QueueDepth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(QueueDepth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/lpd_back.sv]
// lpd_back: word sequencer, emits reset words and nibble-coded channel words
// depends on lpd_pkg
module lpd_back #(
  parameter int unsigned RESET_COUNT = lpd_pkg::ResetCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpd_pkg::pixel_t  head_i,
  input  lpd_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      spi_word_o,
  output logic             last_word_o
);
  import lpd_pkg::*;

  localparam int unsigned NRst = (RESET_COUNT > MaxResults - WordsPerPixel) ?
                                 MaxResults - WordsPerPixel : RESET_COUNT;
  localparam int unsigned PhW  = $clog2(NRst + WordsPerPixel);
  localparam logic [PhW-1:0] PhData = PhW'(NRst);
  localparam logic [PhW-1:0] PhLast = PhW'(NRst + WordsPerPixel - 1);
  localparam logic [PhW-1:0] IdxLast = PhW'(WordsPerPixel - 1);

  logic [PhW-1:0] phase_q, phase_d, cur_phase, idx;
  logic           out_valid_q, out_valid_d;
  logic [15:0]    word_q, word_d;
  logic           last_q, last_d;
  logic           can_load, emit;
  logic [7:0]     sel_byte;

  assign can_load  = !out_valid_q || !out_stall_i;
  assign emit      = can_load && !q_stat_i.empty;
  assign cur_phase = (phase_q == '0 && !head_i.start) ? PhData : phase_q;
  assign idx       = cur_phase - PhData;
  assign pop_o     = emit && (cur_phase == PhLast);

  always_comb begin
    case (idx[2:1])
      2'd0:    sel_byte = head_i.green;
      2'd1:    sel_byte = head_i.red;
      default: sel_byte = head_i.blue;
    endcase
  end

  always_comb begin
    if (cur_phase < PhData) begin
      word_d = '0;
      last_d = 1'b0;
    end else begin
      word_d = nibble_code(idx[0] ? sel_byte[3:0] : sel_byte[7:4]);
      last_d = (idx == IdxLast);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (can_load) begin
      out_valid_d = !q_stat_i.empty;
    end
    if (emit) begin
      phase_d = (cur_phase == PhLast) ? '0 : cur_phase + PhW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign spi_word_o  = word_q;
  assign last_word_o = last_q;

endmodule

[hw/rtl/led_pixel_dim_spi_encoder.sv]
// channel     | handshake                  | payload
// pixel in    | in_valid_i / in_stall_o    | start_frame_i pixel_scale_i red_i green_i blue_i
// word out    | out_valid_o / out_stall_i  | spi_word_o last_word_o
// config      | apb psel penable pwrite    | paddr pwdata prdata, dim level at 0x0
// one word per cycle out unless stalled or queue empty; a pixel is 6 words, 6 + min(RESET_COUNT, 2) with start_frame
// the word sequencer in the back part sets the rate; first word registered after the front register and queue
// front runs two multiply stages, a 2-entry queue lets front and back stall independently
// rst_ni asynchronous active low; clears control state and sets the dim level to 4
// top level: config register and the front, queue and back parts; uses lpd_pkg
module led_pixel_dim_spi_encoder #(
  parameter int unsigned RESET_COUNT = lpd_pkg::ResetCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_frame_i,
  input  logic [7:0]  pixel_scale_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] spi_word_o,
  output logic        last_word_o
);
  import lpd_pkg::*;

  logic [7:0] dim_q, dim_d;
  logic       cfg_wr;
  pixel_t     push_data, head;
  q_stat_t    q_stat;
  logic       push, pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegGlobalDim);
  assign dim_d  = cfg_wr ? pwdata[7:0] : dim_q;
  assign prdata = (paddr[2] == RegGlobalDim) ? {24'd0, dim_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimReset;
    end else begin
      dim_q <= dim_d;
    end
  end

  lpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dim_level_i   (dim_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_frame_i (start_frame_i),
    .pixel_scale_i (pixel_scale_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  lpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  lpd_back #(
    .RESET_COUNT (RESET_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .spi_word_o  (spi_word_o),
    .last_word_o (last_word_o)
  );

endmodule

[hw/rtl/lpd_checker.sv]
// lpd_checker: port-level assertions for the led pixel encoder
// bound to led_pixel_dim_spi_encoder; depends on nothing else
module lpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] spi_word_o,
  input logic        last_word_o
);

  function automatic logic line_ok(input logic [15:0] w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ok = ok && (w[i*4 +: 4] == 4'h8 || w[i*4 +: 4] == 4'hE);
    end
    return ok;
  endfunction

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(spi_word_o) && $stable(last_word_o))
    else $error("stalled word changed");

  a_word_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (spi_word_o == 16'h0000 && !last_word_o) || line_ok(spi_word_o))
    else $error("word is neither a reset word nor line coded");

  a_reset_not_before_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && spi_word_o == 16'h0000 |=> !(out_valid_o && last_word_o))
    else $error("last word right after a reset word");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind led_pixel_dim_spi_encoder lpd_checker u_lpd_checker (.*);
